@@ rtl/grid_astar_path_search_core_macros.svh @@
// Assertion macros shared by the grid path search RTL.
`ifndef GRID_ASTAR_PATH_SEARCH_CORE_MACROS_SVH
`define GRID_ASTAR_PATH_SEARCH_CORE_MACROS_SVH

// Same-cycle implication on clk, quiet while rst_n is low.
`define GAPS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("grid path search: same-cycle check failed");

// Next-cycle implication on clk, quiet while rst_n is low.
`define GAPS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("grid path search: next-cycle check failed");

`endif

@@ rtl/gaps_pkg.sv @@
// Constants, types and direction tables of the grid path search core.
package gaps_pkg;

    localparam int MAX_COLUMNS = 8;
    localparam int MAX_ROWS    = 8;
    localparam int COORD_W     = 3;
    localparam int CELL_W      = 6;
    localparam int NCELLS      = MAX_COLUMNS * MAX_ROWS;
    localparam int DIM_W       = 4;
    localparam int G_W         = 10;
    localparam int F_W         = 11;
    localparam int STAMP_W     = 6;
    localparam int PDIR_W      = 4;
    localparam int PATH_MAX    = 64;

    localparam logic [G_W-1:0]   COST_ORTH = 10'd10;
    localparam logic [G_W-1:0]   COST_DIAG = 10'd14;
    localparam logic [F_W-1:0]   F_MAX     = 11'd2047;
    localparam logic [DIM_W-1:0] DIM_MAX   = 4'd8;

    localparam logic [1:0] REG_COLUMNS = 2'd0;
    localparam logic [1:0] REG_ROWS    = 2'd1;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SEARCH = 1'b1;

    typedef struct packed {
        logic [PDIR_W-1:0]  pdir;
        logic [G_W-1:0]     g;
        logic [F_W-1:0]     f;
        logic [STAMP_W-1:0] stamp;
    } cell_entry_t;

    localparam int ENTRY_W = $bits(cell_entry_t);

    // Step offsets, two-bit two's complement: +x, -x, -y, +y, then diagonals.
    function automatic logic [1:0] dir_dx(input logic [2:0] d);
        logic [1:0] r;
        case (d)
            3'd0:    r = 2'b01;
            3'd1:    r = 2'b11;
            3'd4:    r = 2'b11;
            3'd5:    r = 2'b01;
            3'd6:    r = 2'b11;
            3'd7:    r = 2'b01;
            default: r = 2'b00;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] dir_dy(input logic [2:0] d);
        logic [1:0] r;
        case (d)
            3'd2:    r = 2'b11;
            3'd3:    r = 2'b01;
            3'd4:    r = 2'b11;
            3'd5:    r = 2'b11;
            3'd6:    r = 2'b01;
            3'd7:    r = 2'b01;
            default: r = 2'b00;
        endcase
        return r;
    endfunction

    // Clamp a size register into 1..max.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = 4'd1;
        end
        else if (v > DIM_MAX)
        begin
            r = DIM_MAX;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ rtl/gaps_ram.sv @@
// Generic single-port RAM with registered read data.
module gaps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

@@ rtl/grid_astar_path_search_core.sv @@
// Top level of the 8-connected grid path search core.
//
// Input channel s_axis: one word is either a load (tuser = 0) that writes the
// passable bit of one cell, or a search (tuser = 1) from start to goal. Loads
// give no output word; every search gives one or more output words on
// m_axis, the path cells from the goal back to the start, tlast on the
// start end. tuser on the output is 1 when the goal was reached; an
// unreachable goal, or a start or goal outside the grid, gives the goal
// alone with tuser 0. The config channel sets the grid size (index 0
// columns, index 1 rows) and is always ready; write it only while idle.
// A search closes one cell per round; a round checks the neighbour in
// each in-grid direction (three walk-map reads through the single map
// port per direction), then scans the 64-entry cell store through its
// one read port for the open cell of least f; path words then follow,
// each read back from the store. s_axis_tready is low for the whole
// search and while path words drain; a stalled receiver simply holds
// the block in its output state. Reset clears the control state and the
// per-search open/closed flags; the walk map is undefined until loaded.
module grid_astar_path_search_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] cell_x, [5:3] cell_y, [6] passable, [9:7] start_x,
    // [12:10] start_y, [15:13] goal_x, [18:16] goal_y, rest zero
    input  logic [23:0] s_axis_tdata,
    // [0] action
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [2:0] path_x, [5:3] path_y, rest zero
    output logic [7:0]  m_axis_tdata,
    // [0] found
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);
    import gaps_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLOSE, ST_DIR, ST_W1, ST_W2, ST_W3,
        ST_SCAN, ST_PICK, ST_P_RD, ST_P_WAIT, ST_OUT
    } state_t;

    state_t               state_reg;
    logic [DIM_W-1:0]     cols_reg, rows_reg;
    logic [CELL_W-1:0]    cur_reg, start_reg, goal_reg, par_reg;
    logic [G_W-1:0]       gcur_reg;
    logic [2:0]           dir_reg;
    logic                 wok_reg;
    logic [NCELLS-1:0]    open_reg, closed_reg;
    logic [STAMP_W-1:0]   stamp_cnt_reg;
    logic [CELL_W:0]      scan_idx_reg;
    logic                 chk_vld_reg;
    logic [CELL_W-1:0]    chk_addr_reg;
    logic                 best_vld_reg;
    logic [CELL_W-1:0]    best_reg;
    logic [F_W-1:0]       best_f_reg;
    logic [STAMP_W-1:0]   best_stamp_reg;
    logic [G_W-1:0]       best_g_reg;
    logic [5:0]           k_reg;
    logic                 out_valid_reg, out_found_reg, out_last_reg;
    logic [CELL_W-1:0]    out_cell_reg;

    logic [DIM_W-1:0]     cols_eff, rows_eff;
    logic [COORD_W-1:0]   cx, cy;
    logic [1:0]           dx, dy;
    logic [3:0]           nx4, ny4;
    logic                 inb, diag;
    logic [CELL_W-1:0]    a0, a1, a2;
    logic [COORD_W-1:0]   gx, gy, ax, ay;
    logic [3:0]           mdist;
    logic [7:0]           hval;
    logic [G_W-1:0]       newg;
    logic [F_W:0]         fsum;
    logic [F_W-1:0]       fnew;
    logic                 cand_ok, do_upd;

    logic                 walk_we, walk_wdata, walk_rdata;
    logic [CELL_W-1:0]    walk_addr;
    logic                 cell_we;
    logic [CELL_W-1:0]    cell_addr;
    cell_entry_t          cell_wr, cell_rd;
    logic [ENTRY_W-1:0]   cell_rdata;

    logic [3:0]           pm1;
    logic [1:0]           pdx, pdy;

    logic                 in_acc;
    logic [COORD_W-1:0]   in_cx, in_cy, in_sx, in_sy, in_gx, in_gy;
    logic                 in_pass;
    logic                 se_out;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_cx   = s_axis_tdata[2:0];
    assign in_cy   = s_axis_tdata[5:3];
    assign in_pass = s_axis_tdata[6];
    assign in_sx   = s_axis_tdata[9:7];
    assign in_sy   = s_axis_tdata[12:10];
    assign in_gx   = s_axis_tdata[15:13];
    assign in_gy   = s_axis_tdata[18:16];

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_cell_reg};
    assign m_axis_tuser  = out_found_reg;
    assign m_axis_tlast  = out_last_reg;

    assign cols_eff = eff_dim(cols_reg);
    assign rows_eff = eff_dim(rows_reg);
    assign se_out   = ({1'b0, in_sx} >= cols_eff) || ({1'b0, in_sy} >= rows_eff) ||
                      ({1'b0, in_gx} >= cols_eff) || ({1'b0, in_gy} >= rows_eff);

    // Neighbour geometry of the current cell and direction.
    assign cx   = cur_reg[2:0];
    assign cy   = cur_reg[5:3];
    assign dx   = dir_dx(dir_reg);
    assign dy   = dir_dy(dir_reg);
    assign nx4  = {1'b0, cx} + {{2{dx[1]}}, dx};
    assign ny4  = {1'b0, cy} + {{2{dy[1]}}, dy};
    assign inb  = !nx4[3] && (nx4 < cols_eff) && !ny4[3] && (ny4 < rows_eff);
    assign diag = dir_reg[2];
    assign a0   = {cy, nx4[2:0]};
    assign a1   = {ny4[2:0], cx};
    assign a2   = {ny4[2:0], nx4[2:0]};

    // Heuristic and cost of the step.
    assign gx    = goal_reg[2:0];
    assign gy    = goal_reg[5:3];
    assign ax    = (gx > nx4[2:0]) ? (gx - nx4[2:0]) : (nx4[2:0] - gx);
    assign ay    = (gy > ny4[2:0]) ? (gy - ny4[2:0]) : (ny4[2:0] - gy);
    assign mdist = {1'b0, ax} + {1'b0, ay};
    assign hval  = {1'b0, mdist, 3'b000} + {3'b000, mdist, 1'b0};
    assign newg  = gcur_reg + (diag ? COST_DIAG : COST_ORTH);
    assign fsum  = {2'b00, newg} + {4'b0000, hval};
    assign fnew  = (fsum > {1'b0, F_MAX}) ? F_MAX : fsum[F_W-1:0];

    assign cell_rd = cell_entry_t'(cell_rdata);
    assign cand_ok = (wok_reg || !diag) && walk_rdata && !closed_reg[a2];
    assign do_upd  = cand_ok && (!open_reg[a2] || (newg <= cell_rd.g));

    // Parent of the path cell being read.
    assign pm1 = cell_rd.pdir - 4'd1;
    assign pdx = dir_dx(pm1[2:0]);
    assign pdy = dir_dy(pm1[2:0]);

    always_comb
    begin
        walk_we    = 1'b0;
        walk_wdata = in_pass;
        walk_addr  = {in_cy, in_cx};
        cell_we    = 1'b0;
        cell_addr  = a2;
        cell_wr.pdir  = {1'b0, dir_reg} + 4'd1;
        cell_wr.g     = newg;
        cell_wr.f     = fnew;
        cell_wr.stamp = open_reg[a2] ? cell_rd.stamp : stamp_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                walk_we = in_acc && (s_axis_tuser == ACT_LOAD);
            end
            ST_DIR:
            begin
                walk_addr = a0;
            end
            ST_W1:
            begin
                walk_addr = a1;
            end
            ST_W2:
            begin
                walk_addr = a2;
            end
            ST_W3:
            begin
                walk_addr = a2;
                cell_we   = do_upd;
            end
            ST_SCAN:
            begin
                cell_addr = scan_idx_reg[CELL_W-1:0];
            end
            ST_P_RD:
            begin
                cell_addr = cur_reg;
            end
            default:
            begin
                cell_addr = a2;
            end
        endcase
    end

    gaps_ram #(.WIDTH(1), .DEPTH(NCELLS)) u_walk (
        .clk   (clk),
        .we    (walk_we),
        .addr  (walk_addr),
        .wdata (walk_wdata),
        .rdata (walk_rdata)
    );

    gaps_ram #(.WIDTH(ENTRY_W), .DEPTH(NCELLS)) u_cell (
        .clk   (clk),
        .we    (cell_we),
        .addr  (cell_addr),
        .wdata (cell_wr),
        .rdata (cell_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cols_reg       <= DIM_MAX;
            rows_reg       <= DIM_MAX;
            open_reg       <= '0;
            closed_reg     <= '0;
            out_valid_reg  <= 1'b0;
            chk_vld_reg    <= 1'b0;
            best_vld_reg   <= 1'b0;
            stamp_cnt_reg  <= '0;
            scan_idx_reg   <= '0;
            k_reg          <= '0;
            dir_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_COLUMNS)
                begin
                    cols_reg <= cfg_data;
                end
                else if (cfg_index == REG_ROWS)
                begin
                    rows_reg <= cfg_data;
                end
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && (s_axis_tuser == ACT_SEARCH))
                    begin
                        start_reg     <= {in_sy, in_sx};
                        goal_reg      <= {in_gy, in_gx};
                        cur_reg       <= {in_sy, in_sx};
                        gcur_reg      <= '0;
                        open_reg      <= '0;
                        closed_reg    <= '0;
                        stamp_cnt_reg <= '0;
                        out_cell_reg  <= {in_gy, in_gx};
                        out_last_reg  <= 1'b1;
                        if (se_out)
                        begin
                            out_found_reg <= 1'b0;
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_OUT;
                        end
                        else if ({in_sy, in_sx} == {in_gy, in_gx})
                        begin
                            out_found_reg <= 1'b1;
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_CLOSE;
                        end
                    end
                end
                ST_CLOSE:
                begin
                    closed_reg[cur_reg] <= 1'b1;
                    open_reg[cur_reg]   <= 1'b0;
                    dir_reg             <= '0;
                    state_reg           <= ST_DIR;
                end
                ST_DIR:
                begin
                    if (inb)
                    begin
                        state_reg <= ST_W1;
                    end
                    else if (dir_reg == 3'd7)
                    begin
                        scan_idx_reg <= '0;
                        chk_vld_reg  <= 1'b0;
                        best_vld_reg <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                    else
                    begin
                        dir_reg <= dir_reg + 3'd1;
                    end
                end
                ST_W1:
                begin
                    wok_reg   <= walk_rdata;
                    state_reg <= ST_W2;
                end
                ST_W2:
                begin
                    wok_reg   <= wok_reg && walk_rdata;
                    state_reg <= ST_W3;
                end
                ST_W3:
                begin
                    if (do_upd && !open_reg[a2])
                    begin
                        open_reg[a2]  <= 1'b1;
                        stamp_cnt_reg <= stamp_cnt_reg + 6'd1;
                    end
                    if (dir_reg == 3'd7)
                    begin
                        scan_idx_reg <= '0;
                        chk_vld_reg  <= 1'b0;
                        best_vld_reg <= 1'b0;
                        state_reg    <= ST_SCAN;
                    end
                    else
                    begin
                        dir_reg   <= dir_reg + 3'd1;
                        state_reg <= ST_DIR;
                    end
                end
                ST_SCAN:
                begin
                    // Issue one store read per cycle, judge the word read last cycle.
                    if (!scan_idx_reg[CELL_W])
                    begin
                        chk_vld_reg  <= 1'b1;
                        chk_addr_reg <= scan_idx_reg[CELL_W-1:0];
                        scan_idx_reg <= scan_idx_reg + 7'd1;
                    end
                    else
                    begin
                        chk_vld_reg <= 1'b0;
                        if (!chk_vld_reg)
                        begin
                            state_reg <= ST_PICK;
                        end
                    end
                    if (chk_vld_reg && open_reg[chk_addr_reg] &&
                        (!best_vld_reg || (cell_rd.f < best_f_reg) ||
                         ((cell_rd.f == best_f_reg) && (cell_rd.stamp > best_stamp_reg))))
                    begin
                        best_vld_reg   <= 1'b1;
                        best_reg       <= chk_addr_reg;
                        best_f_reg     <= cell_rd.f;
                        best_stamp_reg <= cell_rd.stamp;
                        best_g_reg     <= cell_rd.g;
                    end
                end
                ST_PICK:
                begin
                    if (!best_vld_reg)
                    begin
                        out_cell_reg  <= goal_reg;
                        out_found_reg <= 1'b0;
                        out_last_reg  <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                    else if (best_reg == goal_reg)
                    begin
                        cur_reg   <= goal_reg;
                        k_reg     <= '0;
                        state_reg <= ST_P_RD;
                    end
                    else
                    begin
                        cur_reg   <= best_reg;
                        gcur_reg  <= best_g_reg;
                        state_reg <= ST_CLOSE;
                    end
                end
                ST_P_RD:
                begin
                    state_reg <= ST_P_WAIT;
                end
                ST_P_WAIT:
                begin
                    // The start cell has no parent; its store word is stale.
                    out_cell_reg  <= cur_reg;
                    out_found_reg <= 1'b1;
                    out_last_reg  <= (cur_reg == start_reg) || (k_reg == 6'(PATH_MAX - 1));
                    out_valid_reg <= 1'b1;
                    par_reg       <= {cy - {pdy[1], pdy}, cx - {pdx[1], pdx}};
                    state_reg     <= ST_OUT;
                end
                ST_OUT:
                begin
                    if (m_axis_tready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            cur_reg   <= par_reg;
                            k_reg     <= k_reg + 6'd1;
                            state_reg <= ST_P_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`include "grid_astar_path_search_core_macros.svh"

    `GAPS_ASSERT_IMP(a_no_take_while_out, s_axis_tready, !m_axis_tvalid)
    `GAPS_ASSERT_IMP(a_miss_single, m_axis_tvalid && !m_axis_tuser, m_axis_tlast)
    `GAPS_ASSERT_IMP(a_path_cut, m_axis_tvalid && (k_reg == 6'(PATH_MAX - 1)), m_axis_tlast)
    `GAPS_ASSERT_IMP(a_open_closed_apart, 1'b1, (open_reg & closed_reg) == '0)
    `GAPS_ASSERT_NXT(a_search_closes_start, (state_reg == ST_CLOSE) && (cur_reg == start_reg),
        closed_reg[start_reg])

endmodule
